// ----- sv/hlae_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlae_pkg
// Shared types, character codes and helpers for the HTML link extractor.
// ----------------------------------------------------------------------------
package hlae_pkg;

    // Character codes
    localparam logic [7:0] C_LT     = 8'h3C; // '<'
    localparam logic [7:0] C_GT     = 8'h3E; // '>'
    localparam logic [7:0] C_DQUOTE = 8'h22;
    localparam logic [7:0] C_SQUOTE = 8'h27;
    localparam logic [7:0] C_SPACE  = 8'h20;
    localparam logic [7:0] C_TAB    = 8'h09;
    localparam logic [7:0] C_LF     = 8'h0A;
    localparam logic [7:0] C_VT     = 8'h0B;
    localparam logic [7:0] C_FF     = 8'h0C;
    localparam logic [7:0] C_CR     = 8'h0D;
    localparam logic [7:0] C_A      = 8'h61; // 'a'
    localparam logic [7:0] C_C      = 8'h63; // 'c'
    localparam logic [7:0] C_E      = 8'h65; // 'e'
    localparam logic [7:0] C_F      = 8'h66; // 'f'
    localparam logic [7:0] C_H      = 8'h68; // 'h'
    localparam logic [7:0] C_I      = 8'h69; // 'i'
    localparam logic [7:0] C_R      = 8'h72; // 'r'
    localparam logic [7:0] C_S      = 8'h73; // 's'

    // Bytes skipped after "<i" and the count of them
    localparam logic [2:0] FRAME_LEN = 3'd6;

    // Queue depth between front and back
    localparam int QUEUE_DEPTH = 2;

    // Parser modes
    typedef enum logic [3:0] {
        MODE_IDLE  = 4'd0,
        MODE_LT    = 4'd1,
        MODE_ACHK  = 4'd2,
        MODE_SKIP  = 4'd3,
        MODE_S1    = 4'd4,
        MODE_S2    = 4'd5,
        MODE_H1    = 4'd6,
        MODE_H2    = 4'd7,
        MODE_H3    = 4'd8,
        MODE_SEEK  = 4'd9,
        MODE_FIRST = 4'd10,
        MODE_VALUE = 4'd11
    } t_mode;

    // One classified text byte
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       ws;
        logic       quote;
        logic       lt;
        logic       gt;
    } t_item;

    // Expected byte of "frame " at a given position
    function automatic logic [7:0] frame_char(input logic [2:0] idx);
        logic [7:0] ch;
        begin
            case (idx)
                3'd0:    ch = C_F;
                3'd1:    ch = C_R;
                3'd2:    ch = C_A;
                3'd3:    ch = 8'h6D; // 'm'
                3'd4:    ch = C_E;
                3'd5:    ch = C_SPACE;
                default: ch = 8'h00;
            endcase
            return ch;
        end
    endfunction

endpackage

// ----- sv/html_link_attribute_extractor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// html_link_attribute_extractor
// Streams HTML text a byte at a time and emits the src/href attribute values
// that start with 'h' in link tags, one character per transfer, last marked.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata            tlast
// s_axis    in   [7:0] text_byte  text_last
// m_axis    out  [7:0] link_byte  link_last
//
// Throughput: one byte per cycle on both sides unless the output stalls.
// Path: a byte enters the two-entry queue, the parser takes it from there
// into the held-byte register, and the held byte moves to the output
// register when the parser consumes the byte after it.
// Reset: synchronous, active low; clears the queue, parser state and output.
// Stalls: a stalled output register holds the parser; the queue absorbs two
// bytes before the input side deasserts tready.
// ----------------------------------------------------------------------------
module html_link_attribute_extractor
    import hlae_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] text_byte
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] link_byte
    output logic       o_m_axis_tlast
);

    logic  front_push;
    t_item front_item;
    logic  queue_ready;
    logic  queue_valid;
    t_item queue_item;
    logic  back_pop;

    hlae_front u_front (
        .i_valid       (i_s_axis_tvalid),
        .i_data        (i_s_axis_tdata),
        .i_last        (i_s_axis_tlast),
        .i_queue_ready (queue_ready),
        .o_ready       (o_s_axis_tready),
        .o_push        (front_push),
        .o_item        (front_item)
    );

    hlae_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_item  (front_item),
        .o_ready (queue_ready),
        .i_pop   (back_pop),
        .o_valid (queue_valid),
        .o_item  (queue_item)
    );

    hlae_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (queue_valid),
        .i_item  (queue_item),
        .o_pop   (back_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata),
        .o_last  (o_m_axis_tlast)
    );

endmodule

// ----- sv/hlae_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlae_front
// Accepts text bytes and tags each with its character class for the parser.
// ----------------------------------------------------------------------------
module hlae_front
    import hlae_pkg::*;
(
    input  logic       i_valid,
    input  logic [7:0] i_data,
    input  logic       i_last,
    input  logic       i_queue_ready,
    output logic       o_ready,
    output logic       o_push,
    output t_item      o_item
);

    // Pass queue space back to the source
    assign o_ready = i_queue_ready;
    assign o_push  = i_valid & i_queue_ready;

    // Classify the byte
    always_comb begin
        o_item.data  = i_data;
        o_item.last  = i_last;
        o_item.ws    = (i_data == C_SPACE) || (i_data == C_TAB) || (i_data == C_LF) ||
                       (i_data == C_VT) || (i_data == C_FF) || (i_data == C_CR);
        o_item.quote = (i_data == C_DQUOTE) || (i_data == C_SQUOTE);
        o_item.lt    = (i_data == C_LT);
        o_item.gt    = (i_data == C_GT);
    end

endmodule

// ----- sv/hlae_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlae_queue
// Two-entry queue of classified bytes between the front and the parser.
// ----------------------------------------------------------------------------
module hlae_queue
    import hlae_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_ready,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- sv/hlae_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlae_back
// Tag and attribute parser with a held byte and the link output register.
// ----------------------------------------------------------------------------
module hlae_back
    import hlae_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_item      i_item,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_data,
    output logic       o_last
);

    t_mode      r_mode, n_mode;
    logic       r_tag_open, n_tag_open;
    logic [2:0] r_skip, n_skip;
    logic       r_frame, n_frame;
    logic [7:0] r_held, n_held;
    logic       r_out_valid;
    logic [7:0] r_out_data;
    logic       r_out_last;

    logic       emit;
    logic       emit_last;
    logic [7:0] c;

    assign c       = i_item.data;
    assign o_pop   = i_valid & (~r_out_valid | i_ready);
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_last  = r_out_last;

    // Next mode
    always_comb begin
        n_mode = r_mode;
        unique case (r_mode)
            MODE_LT: begin
                if (i_item.ws)       n_mode = MODE_LT;
                else if (c == C_A)   n_mode = MODE_ACHK;
                else if (c == C_I)   n_mode = MODE_SKIP;
                else                 n_mode = MODE_IDLE;
            end
            MODE_SKIP: begin
                if (r_skip == 3'd1)  n_mode = MODE_IDLE;
            end
            MODE_S1: begin
                if (c == C_R)        n_mode = MODE_S2;
                else                 n_mode = MODE_IDLE;
            end
            MODE_S2: begin
                if (c == C_C)        n_mode = MODE_SEEK;
                else                 n_mode = MODE_IDLE;
            end
            MODE_H1: begin
                if (c == C_R)        n_mode = MODE_H2;
                else                 n_mode = MODE_IDLE;
            end
            MODE_H2: begin
                if (c == C_E)        n_mode = MODE_H3;
                else                 n_mode = MODE_IDLE;
            end
            MODE_H3: begin
                if (c == C_F)        n_mode = MODE_SEEK;
                else                 n_mode = MODE_IDLE;
            end
            MODE_SEEK: begin
                if (i_item.quote)    n_mode = MODE_FIRST;
            end
            MODE_FIRST: begin
                if (c == C_H && !i_item.last) n_mode = MODE_VALUE;
                else                          n_mode = MODE_IDLE;
            end
            MODE_VALUE: begin
                if (i_item.quote || i_item.last) n_mode = MODE_IDLE;
            end
            MODE_ACHK: begin
                n_mode = MODE_IDLE;
            end
            default: begin
                n_mode = MODE_IDLE;
            end
        endcase

        // Re-examine a byte that broke a partial match, or any byte in idle
        if ((r_mode == MODE_IDLE) ||
            (r_mode == MODE_ACHK && !i_item.ws) ||
            (r_mode == MODE_S1 && c != C_R) || (r_mode == MODE_S2 && c != C_C) ||
            (r_mode == MODE_H1 && c != C_R) || (r_mode == MODE_H2 && c != C_E) ||
            (r_mode == MODE_H3 && c != C_F)) begin
            if (i_item.lt)                n_mode = MODE_LT;
            else if (c == C_S && r_tag_open) n_mode = MODE_S1;
            else if (c == C_H && r_tag_open) n_mode = MODE_H1;
            else                          n_mode = MODE_IDLE;
        end

        // End of document returns to idle
        if (i_item.last) n_mode = MODE_IDLE;
    end

    // Tag flag, skip counter, held byte and result
    always_comb begin
        n_tag_open = r_tag_open;
        n_skip     = r_skip;
        n_frame    = r_frame;
        n_held     = r_held;
        emit       = 1'b0;
        emit_last  = 1'b0;
        unique case (r_mode)
            MODE_LT: begin
                if (!i_item.ws && c == C_I) begin
                    n_skip  = FRAME_LEN;
                    n_frame = 1'b1;
                end
            end
            MODE_ACHK: begin
                if (i_item.ws)     n_tag_open = 1'b1;
                else if (i_item.gt) n_tag_open = 1'b0;
            end
            MODE_SKIP: begin
                n_frame = r_frame & (c == frame_char(FRAME_LEN - r_skip));
                n_skip  = r_skip - 3'd1;
                if (r_skip == 3'd1) begin
                    if (n_frame) n_tag_open = 1'b1;
                    n_frame = 1'b0;
                end
            end
            MODE_S1: begin
                if (c != C_R && i_item.gt) n_tag_open = 1'b0;
            end
            MODE_S2: begin
                if (c != C_C && i_item.gt) n_tag_open = 1'b0;
            end
            MODE_H1: begin
                if (c != C_R && i_item.gt) n_tag_open = 1'b0;
            end
            MODE_H2: begin
                if (c != C_E && i_item.gt) n_tag_open = 1'b0;
            end
            MODE_H3: begin
                if (c != C_F && i_item.gt) n_tag_open = 1'b0;
            end
            MODE_FIRST: begin
                if (c == C_H && !i_item.last) n_held = c;
            end
            MODE_VALUE: begin
                emit = 1'b1;
                if (i_item.quote || i_item.last) begin
                    emit_last  = 1'b1;
                    n_tag_open = 1'b0;
                end else begin
                    n_held = c;
                end
            end
            MODE_SEEK: begin
                n_tag_open = r_tag_open;
            end
            default: begin
                if (i_item.gt) n_tag_open = 1'b0;
            end
        endcase

        // Clear the tag flag, skip counter and frame flag after the final byte
        if (i_item.last) begin
            n_tag_open = 1'b0;
            n_skip     = '0;
            n_frame    = 1'b0;
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IDLE;
            r_tag_open <= 1'b0;
            r_skip     <= '0;
            r_frame    <= 1'b0;
        end else if (o_pop) begin
            r_mode     <= n_mode;
            r_tag_open <= n_tag_open;
            r_skip     <= n_skip;
            r_frame    <= n_frame;
        end
    end

    // Held byte
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_held <= n_held;
        end
    end

    // Output register: load a new link byte, drop a taken one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= emit;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_out_data <= r_held;
            r_out_last <= emit_last;
        end
    end

endmodule

// ----- verif/hlae_link_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlae_link_checker
// Watches both stream channels of the HTML link extractor. Every accepted
// text byte goes through a local link parser that predicts the characters
// the block must emit. Every output transfer is compared with the oldest
// prediction. The failure count and the number of pending predictions go
// back to the testbench top.
// ----------------------------------------------------------------------------
module hlae_link_checker
    import hlae_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_s_tready,
    input  logic [7:0] i_s_tdata,    // [7:0] text_byte
    input  logic       i_s_tlast,
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,    // [7:0] link_byte
    input  logic       i_m_tlast,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_link_chars,
    output int         o_links
);

    // One predicted link character
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_link_char;

    localparam string FRAME_TAIL = "frame ";

    t_link_char link_char_q[$];

    // Local copy of the parser state
    t_mode      scan_mode;
    logic       tag_open;
    logic [2:0] skip_left;
    logic       frame_ok;
    logic [7:0] held_char;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_link_chars = 0;
        o_links      = 0;
    end

    function automatic logic is_space(input logic [7:0] c);
        return (c == C_SPACE) || (c == C_TAB) || (c == C_LF) ||
               (c == C_VT) || (c == C_FF) || (c == C_CR);
    endfunction

    function automatic logic is_quote_char(input logic [7:0] c);
        return (c == C_DQUOTE) || (c == C_SQUOTE);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] link check: %s", $time, msg);
        o_fail_count++;
    endtask

    // Look at a byte as if no partial match were in progress
    task automatic rescan(input logic [7:0] c);
        scan_mode = MODE_IDLE;
        if (c == C_GT) begin
            tag_open = 1'b0;
        end else if (c == C_LT) begin
            scan_mode = MODE_LT;
        end else if (c == C_S && tag_open) begin
            scan_mode = MODE_S1;
        end else if (c == C_H && tag_open) begin
            scan_mode = MODE_H1;
        end
    endtask

    task automatic clear_parser();
        scan_mode = MODE_IDLE;
        tag_open  = 1'b0;
        skip_left = '0;
        frame_ok  = 1'b0;
        held_char = '0;
    endtask

    // Advance the parser by one text byte and queue any link character
    task automatic parse_text_byte(input logic [7:0] c, input logic last);
        logic [2:0] idx;
        logic       done;
        t_link_char nxt;
        case (scan_mode)
            MODE_LT: begin
                if (is_space(c)) begin
                    scan_mode = MODE_LT;
                end else if (c == C_A) begin
                    scan_mode = MODE_ACHK;
                end else if (c == C_I) begin
                    scan_mode = MODE_SKIP;
                    skip_left = FRAME_LEN;
                    frame_ok  = 1'b1;
                end else begin
                    scan_mode = MODE_IDLE;
                end
            end
            MODE_ACHK: begin
                if (is_space(c)) begin
                    tag_open  = 1'b1;
                    scan_mode = MODE_IDLE;
                end else begin
                    rescan(c);
                end
            end
            MODE_SKIP: begin
                idx = FRAME_LEN - skip_left;
                if (c != FRAME_TAIL[idx])
                    frame_ok = 1'b0;
                skip_left = skip_left - 3'd1;
                if (skip_left == 3'd0) begin
                    if (frame_ok)
                        tag_open = 1'b1;
                    frame_ok  = 1'b0;
                    scan_mode = MODE_IDLE;
                end
            end
            MODE_S1: if (c == C_R) scan_mode = MODE_S2;   else rescan(c);
            MODE_S2: if (c == C_C) scan_mode = MODE_SEEK; else rescan(c);
            MODE_H1: if (c == C_R) scan_mode = MODE_H2;   else rescan(c);
            MODE_H2: if (c == C_E) scan_mode = MODE_H3;   else rescan(c);
            MODE_H3: if (c == C_F) scan_mode = MODE_SEEK; else rescan(c);
            MODE_SEEK: begin
                if (is_quote_char(c))
                    scan_mode = MODE_FIRST;
            end
            MODE_FIRST: begin
                if (c == C_H && !last) begin
                    held_char = c;
                    scan_mode = MODE_VALUE;
                end else begin
                    scan_mode = MODE_IDLE;
                end
            end
            MODE_VALUE: begin
                // The held byte goes out; a quote or the end of text closes it
                done     = is_quote_char(c) || last;
                nxt.ch   = held_char;
                nxt.last = done;
                link_char_q.insert(link_char_q.size(), nxt);
                if (done) begin
                    tag_open  = 1'b0;
                    scan_mode = MODE_IDLE;
                end else begin
                    held_char = c;
                end
            end
            default: rescan(c);
        endcase
        if (last)
            clear_parser();
    endtask

    // Compare output transfers first, then predict from input transfers
    always @(posedge i_clk) begin
        t_link_char exp_char;
        if (!i_rst_n) begin
            clear_parser();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                o_link_chars++;
                if (i_m_tlast)
                    o_links++;
                if (link_char_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected link byte %02h last %0b",
                                              i_m_tdata, i_m_tlast));
                end else begin
                    exp_char = link_char_q.pop_front();
                    if (i_m_tdata !== exp_char.ch)
                        report_mismatch($sformatf("link byte %02h, predicted %02h",
                                                  i_m_tdata, exp_char.ch));
                    if (i_m_tlast !== exp_char.last)
                        report_mismatch($sformatf("link last %0b, predicted %0b (byte %02h)",
                                                  i_m_tlast, exp_char.last, exp_char.ch));
                end
            end
            if (i_s_tvalid && i_s_tready)
                parse_text_byte(i_s_tdata, i_s_tlast);
        end
        o_pending = link_char_q.size();
    end

endmodule

// ----- verif/tb_html_link_attribute_extractor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_html_link_attribute_extractor
// Feeds HTML documents to the link extractor: a few hand-written ones for
// the corner cases, then random documents built mostly from well-formed
// link tags with random content, mixed with noise and broken tags. Both
// sides idle at random and the output side holds off for long stretches.
// A checker module predicts and compares every link character.
// ----------------------------------------------------------------------------
module tb_html_link_attribute_extractor
    import hlae_pkg::*;
();

    localparam int RANDOM_BYTES = 1250;
    localparam int LONG_HOLD    = 300;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;       // [7:0] text_byte
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;       // [7:0] link_byte
    logic       m_tlast;

    logic       s_taken;
    logic       m_taken;

    int         fail_count;
    int         pending;
    int         link_chars;
    int         links;

    int         bytes_sent;
    int         docs_sent;
    int         rx_count;
    int         long_holds;
    int         tx_calm_left;
    int         rx_calm_left;

    logic [7:0] doc_q[$];
    logic [7:0] ws_set [6] = '{C_SPACE, C_TAB, C_LF, C_VT, C_FF, C_CR};

    html_link_attribute_extractor DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    hlae_link_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_link_chars (link_chars),
        .o_links      (links)
    );

    // 20 ns clock
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Record transfers at the rising edge for the drivers at the falling edge
    always @(posedge clk) begin
        s_taken <= s_tvalid && s_tready;
        m_taken <= m_tvalid && m_tready;
    end

    // Draw an idle gap, with occasional stretches of none
    function automatic int draw_gap(ref int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
            calm_left = $urandom_range(20, 60);
        return $urandom_range(0, 15);
    endfunction

    // Offer one text byte and hold it until the transfer
    task automatic push_text(input logic [7:0] c, input logic last);
        int gap;
        gap = draw_gap(tx_calm_left);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do @(negedge clk); while (!s_taken);
        bytes_sent++;
    endtask

    // Append one byte to the document being built
    task automatic add_byte(input logic [7:0] b);
        doc_q.insert(doc_q.size(), b);
    endtask

    // Send the built document, last marked on its final byte
    task automatic send_doc();
        for (int k = 0; k < doc_q.size(); k++)
            push_text(doc_q[k], k == doc_q.size() - 1);
        doc_q.delete();
        docs_sent++;
    endtask

    task automatic add_str(input string s);
        for (int k = 0; k < s.len(); k++)
            add_byte(s[k]);
    endtask

    task automatic add_ws(input int lo, input int hi);
        int n;
        n = $urandom_range(lo, hi);
        repeat (n) add_byte(ws_set[$urandom_range(0, 5)]);
    endtask

    task automatic add_filler(input string pool, input int hi);
        int n;
        n = $urandom_range(0, hi);
        repeat (n) add_byte(pool[$urandom_range(0, pool.len() - 1)]);
    endtask

    function automatic logic [7:0] pick_quote();
        return $urandom_range(0, 1) ? C_DQUOTE : C_SQUOTE;
    endfunction

    // Append a link tag with random content, sometimes slightly broken
    task automatic add_link_tag();
        string      tail;
        logic [7:0] b;
        int         n;
        add_str("<");
        add_ws(0, 2);
        if ($urandom_range(0, 1)) begin
            add_str("a");
            add_ws(1, 2);
        end else begin
            tail = "frame ";
            if ($urandom_range(0, 5) == 0)
                tail[$urandom_range(0, 5)] = "x";
            add_str("i");
            add_str(tail);
        end
        add_filler("tx=d ", 3);
        case ($urandom_range(0, 9))
            0:       add_str("sr");
            1:       add_str("hre");
            2, 3, 4: add_str("src");
            default: add_str("href");
        endcase
        add_filler("= ", 2);
        add_byte(pick_quote());
        if ($urandom_range(0, 9) != 0)
            add_byte(C_H);
        n = $urandom_range(0, 8);
        repeat (n) begin
            b = 8'($urandom_range(0, 255));
            if (b == C_DQUOTE || b == C_SQUOTE)
                b = b + 8'd1;
            add_byte(b);
        end
        if ($urandom_range(0, 7) != 0)
            add_byte(pick_quote());
        add_str(">");
    endtask

    // Build one random document out of a few fragments
    task automatic build_random_doc();
        int frags;
        int n;
        frags = $urandom_range(1, 6);
        repeat (frags) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: add_link_tag();
                6, 7: begin
                    n = $urandom_range(1, 6);
                    repeat (n) add_byte(8'($urandom_range(0, 255)));
                end
                8: begin
                    add_str("<");
                    add_filler("ab<> i", 3);
                end
                default: add_str(">");
            endcase
        end
        // Cut some documents short so the text ends mid-tag or mid-value
        if ($urandom_range(0, 4) == 0 && doc_q.size() > 1) begin
            n = $urandom_range(1, doc_q.size());
            while (doc_q.size() > n)
                void'(doc_q.pop_back());
        end
    endtask

    // Output side: random stalls plus a couple of long hold-offs
    initial begin
        int gap;
        m_tready     = 1'b0;
        rx_count     = 0;
        long_holds   = 0;
        rx_calm_left = 0;
        do @(negedge clk); while (!rst_n);
        forever begin
            if (rx_count == 10 || rx_count == 120) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                long_holds++;
            end else begin
                gap = draw_gap(rx_calm_left);
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            m_tready <= 1'b1;
            do @(negedge clk); while (!m_taken);
            rx_count++;
        end
    end

    // Stimulus and verdict
    initial begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        bytes_sent   = 0;
        docs_sent    = 0;
        tx_calm_left = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Whitespace kinds, href value closed by a quote, then an iframe
        // src value that the end of text cuts off
        add_str("<\ta\nhref=\"hi\"");
        add_str("<iframe src'hq");
        send_doc();
        // Extreme bytes, 'a' without whitespace, 'h' as the very last byte
        add_byte(8'hFF);
        add_byte(8'h00);
        add_str("<ab <a src'h");
        send_doc();

        // Random documents
        while (bytes_sent < RANDOM_BYTES + 30) begin
            build_random_doc();
            send_doc();
        end
        s_tvalid <= 1'b0;

        // Drain, then watch for stray output a little longer
        while (pending != 0) @(negedge clk);
        repeat (10) @(negedge clk);

        $display("Sent %0d text bytes in %0d documents; received %0d link bytes in %0d links.",
                 bytes_sent, docs_sent, link_chars, links);
        $display("Output side held off for %0d long stretches.", long_holds);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("Watchdog expired with %0d link bytes still expected.", pending);
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/hlae_pkg.sv
sv/hlae_front.sv
sv/hlae_queue.sv
sv/hlae_back.sv
sv/html_link_attribute_extractor.sv
verif/hlae_link_checker.sv
verif/tb_html_link_attribute_extractor.sv
